// ===== sv/eps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eps_pkg
// types, widths, microcode program and control encodings of the potential sum
// ----------------------------------------------------------------------------
package eps_pkg;

    localparam int POS_W     = 24;
    localparam int CHG_W     = 16;
    localparam int D_W       = POS_W + 1;
    localparam int D2_W      = 2 * D_W;
    localparam int ROOT_W    = D2_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int QUO_W     = CHG_W + 28;
    localparam int FRAC_SH   = 28;
    localparam int SUM_W     = 48;
    localparam int SCALE_W   = 32;
    localparam int HALF_W    = SCALE_W / 2;
    localparam int PROD_W    = SUM_W + D_W;
    localparam int SACC_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int PC_W      = 4;
    localparam int CNT_W     = 6;
    localparam int SQRT_ITER = ROOT_W;
    localparam int DIV_ITER  = QUO_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [POS_W-1:0]   CENTER_RESET = '0;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_SCALE    = 3'd3,
        REG_ENABLE   = 3'd4
    } eps_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ACCUM,
        OP_ZERO,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_EMIT
    } eps_op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_LOOP,
        C_IF_ZERO,
        C_LAST_ELSE_END,
        C_END
    } eps_cond_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } eps_seq_state_t;

    typedef struct packed {
        eps_op_t           op;
        eps_cond_t         cond;
        logic [PC_W-1:0]   target;
        logic              load_cnt;
        logic [CNT_W-1:0]  iter;
    } eps_uword_t;

    typedef struct packed {
        logic d2_zero;
        logic last;
        logic emit_ok;
    } eps_stat_t;

    localparam logic [PC_W-1:0] S_SQ_X      = 4'd0;
    localparam logic [PC_W-1:0] S_SQ_Y      = 4'd1;
    localparam logic [PC_W-1:0] S_SQ_Z      = 4'd2;
    localparam logic [PC_W-1:0] S_SQRT_INIT = 4'd3;
    localparam logic [PC_W-1:0] S_SQRT      = 4'd4;
    localparam logic [PC_W-1:0] S_DIV_INIT  = 4'd5;
    localparam logic [PC_W-1:0] S_DIV       = 4'd6;
    localparam logic [PC_W-1:0] S_ACCUM     = 4'd7;
    localparam logic [PC_W-1:0] S_MUL_HI    = 4'd8;
    localparam logic [PC_W-1:0] S_MUL_LO    = 4'd9;
    localparam logic [PC_W-1:0] S_EMIT      = 4'd10;
    localparam logic [PC_W-1:0] S_ZERO      = 4'd11;

    function automatic eps_uword_t eps_rom(input logic [PC_W-1:0] addr);
        eps_uword_t w;
        w = '{OP_NOP, C_END, '0, 1'b0, '0};
        case (addr)
            S_SQ_X:      w = '{OP_SQ_X, C_NEXT, '0, 1'b0, '0};
            S_SQ_Y:      w = '{OP_SQ_Y, C_NEXT, '0, 1'b0, '0};
            S_SQ_Z:      w = '{OP_SQ_Z, C_NEXT, '0, 1'b0, '0};
            S_SQRT_INIT: w = '{OP_SQRT_INIT, C_IF_ZERO, S_ZERO, 1'b1,
                               CNT_W'(SQRT_ITER - 1)};
            S_SQRT:      w = '{OP_SQRT_STEP, C_LOOP, '0, 1'b0, '0};
            S_DIV_INIT:  w = '{OP_DIV_INIT, C_NEXT, '0, 1'b1, CNT_W'(DIV_ITER - 1)};
            S_DIV:       w = '{OP_DIV_STEP, C_LOOP, '0, 1'b0, '0};
            S_ACCUM:     w = '{OP_ACCUM, C_LAST_ELSE_END, S_MUL_HI, 1'b0, '0};
            S_MUL_HI:    w = '{OP_MUL_HI, C_NEXT, '0, 1'b0, '0};
            S_MUL_LO:    w = '{OP_MUL_LO, C_NEXT, '0, 1'b0, '0};
            S_EMIT:      w = '{OP_EMIT, C_END, '0, 1'b0, '0};
            S_ZERO:      w = '{OP_ZERO, C_LAST_ELSE_END, S_MUL_HI, 1'b0, '0};
            default:     w = '{OP_NOP, C_END, '0, 1'b0, '0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== sv/eps_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eps_in_if
// charge word channel: charge, position and end-of-run mark
// ----------------------------------------------------------------------------
interface eps_in_if;

    logic                            valid;
    logic                            ready;
    logic [eps_pkg::CHG_W-1:0]       charge;
    logic [eps_pkg::POS_W-1:0]       pos_x;
    logic [eps_pkg::POS_W-1:0]       pos_y;
    logic [eps_pkg::POS_W-1:0]       pos_z;
    logic                            last;

    modport source (
        output valid, charge, pos_x, pos_y, pos_z, last,
        input  ready
    );

    modport sink (
        input  valid, charge, pos_x, pos_y, pos_z, last,
        output ready
    );

endinterface
`default_nettype wire

// ===== sv/eps_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eps_out_if
// result word channel: scaled potential and run flags
// ----------------------------------------------------------------------------
interface eps_out_if;

    logic                        valid;
    logic                        ready;
    logic [eps_pkg::SUM_W-1:0]   potential;
    logic                        zero_distance_seen;
    logic                        saturated;

    modport source (
        output valid, potential, zero_distance_seen, saturated,
        input  ready
    );

    modport sink (
        input  valid, potential, zero_distance_seen, saturated,
        output ready
    );

endinterface
`default_nettype wire

// ===== sv/eps_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eps_seq
// microcode sequencer: step counter, loop counter and conditional jumps
// ----------------------------------------------------------------------------
module eps_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire eps_pkg::eps_stat_t  stat,
    output eps_pkg::eps_op_t         op,
    output logic                     busy
);

    eps_pkg::eps_seq_state_t         state_reg, state_next;
    logic [eps_pkg::PC_W-1:0]        pc_reg, pc_next;
    logic [eps_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    eps_pkg::eps_uword_t             uw;
    logic                            stall;

    assign uw   = eps_pkg::eps_rom(pc_reg);
    assign busy = (state_reg == eps_pkg::SEQ_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eps_pkg::SEQ_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        op         = eps_pkg::OP_NOP;
        stall      = (uw.op == eps_pkg::OP_EMIT) && !stat.emit_ok;
        case (state_reg)
            eps_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = eps_pkg::SEQ_RUN;
                    pc_next    = eps_pkg::S_SQ_X;
                end
            end
            eps_pkg::SEQ_RUN:
            begin
                if (!stall)
                begin
                    op = uw.op;
                    if (uw.load_cnt)
                    begin
                        cnt_next = uw.iter;
                    end
                    case (uw.cond)
                        eps_pkg::C_NEXT:
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                        eps_pkg::C_LOOP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                pc_next = pc_reg + 1'b1;
                            end
                        end
                        eps_pkg::C_IF_ZERO:
                        begin
                            pc_next = stat.d2_zero ? uw.target : pc_reg + 1'b1;
                        end
                        eps_pkg::C_LAST_ELSE_END:
                        begin
                            if (stat.last)
                            begin
                                pc_next = uw.target;
                            end
                            else
                            begin
                                state_next = eps_pkg::SEQ_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = eps_pkg::SEQ_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = eps_pkg::SEQ_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/eps_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eps_dp
// datapath: offsets, shared multiplier, bit-serial root and divide,
// saturating sum and result register
// ----------------------------------------------------------------------------
module eps_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            load,
    input  wire logic                            clear,
    input  wire eps_pkg::eps_op_t                op,
    input  wire logic [eps_pkg::CHG_W-1:0]       charge,
    input  wire logic [eps_pkg::POS_W-1:0]       pos_x,
    input  wire logic [eps_pkg::POS_W-1:0]       pos_y,
    input  wire logic [eps_pkg::POS_W-1:0]       pos_z,
    input  wire logic                            last,
    input  wire logic [eps_pkg::POS_W-1:0]       center_x,
    input  wire logic [eps_pkg::POS_W-1:0]       center_y,
    input  wire logic [eps_pkg::POS_W-1:0]       center_z,
    input  wire logic [eps_pkg::SCALE_W-1:0]     scale_recip,
    input  wire logic                            out_ready,
    output eps_pkg::eps_stat_t                   stat,
    output logic                                 out_valid,
    output logic [eps_pkg::SUM_W-1:0]            potential,
    output logic                                 zero_distance_seen,
    output logic                                 saturated
);

    localparam int D_W    = eps_pkg::D_W;
    localparam int D2_W   = eps_pkg::D2_W;
    localparam int ROOT_W = eps_pkg::ROOT_W;
    localparam int REM_W  = eps_pkg::REM_W;
    localparam int QUO_W  = eps_pkg::QUO_W;
    localparam int SUM_W  = eps_pkg::SUM_W;
    localparam int PROD_W = eps_pkg::PROD_W;
    localparam int SACC_W = eps_pkg::SACC_W;
    localparam int CHG_W  = eps_pkg::CHG_W;
    localparam int HALF_W = eps_pkg::HALF_W;

    // payload
    logic [CHG_W-1:0]   q_reg, q_next;
    logic [D_W-1:0]     dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic               last_reg, last_next;
    logic [D2_W-1:0]    d2_reg, d2_next;
    logic [D2_W-1:0]    work_reg, work_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [SACC_W-1:0]  sacc_reg, sacc_next;
    logic [SUM_W-1:0]   pot_reg, pot_next;
    logic               pzero_reg, pzero_next, psat_reg, psat_next;

    // run state
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               zero_flag_reg, zero_flag_next;
    logic               sat_flag_reg, sat_flag_next;
    logic               out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]   mul_a;
    logic [D_W-1:0]     mul_b;
    logic [PROD_W-1:0]  prod;
    logic [D_W-1:0]     abs_dx, abs_dy, abs_dz;
    logic [CHG_W-1:0]   abs_q;
    logic [SUM_W-1:0]   abs_sum;
    logic [REM_W+1:0]   sq_rem, sq_trial;
    logic [ROOT_W:0]    dv_rem;
    logic [QUO_W-1:0]   quo;
    logic [SUM_W:0]     term, sum_ext;

    assign abs_dx  = dx_reg[D_W-1] ? D_W'(~dx_reg + 1'b1) : dx_reg;
    assign abs_dy  = dy_reg[D_W-1] ? D_W'(~dy_reg + 1'b1) : dy_reg;
    assign abs_dz  = dz_reg[D_W-1] ? D_W'(~dz_reg + 1'b1) : dz_reg;
    assign abs_q   = q_reg[CHG_W-1] ? CHG_W'(~q_reg + 1'b1) : q_reg;
    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(~sum_reg + 1'b1) : sum_reg;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            eps_pkg::OP_SQ_X:
            begin
                mul_a = SUM_W'(abs_dx);
                mul_b = abs_dx;
            end
            eps_pkg::OP_SQ_Y:
            begin
                mul_a = SUM_W'(abs_dy);
                mul_b = abs_dy;
            end
            eps_pkg::OP_SQ_Z:
            begin
                mul_a = SUM_W'(abs_dz);
                mul_b = abs_dz;
            end
            eps_pkg::OP_MUL_HI:
            begin
                mul_a = abs_sum;
                mul_b = D_W'(scale_recip[2*HALF_W-1:HALF_W]);
            end
            eps_pkg::OP_MUL_LO:
            begin
                mul_a = abs_sum;
                mul_b = D_W'(scale_recip[HALF_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // one root bit per step
    assign sq_rem   = {rem_reg, work_reg[D2_W-1:D2_W-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // one quotient bit per step
    assign dv_rem = {rem_reg[ROOT_W-1:0], work_reg[QUO_W-1]};
    assign quo    = work_reg[QUO_W-1:0];

    assign term    = q_reg[CHG_W-1] ? (~(SUM_W+1)'(quo) + 1'b1) : (SUM_W+1)'(quo);
    assign sum_ext = {sum_reg[SUM_W-1], sum_reg} + term;

    always_comb
    begin
        q_next         = q_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        last_next      = last_reg;
        d2_next        = d2_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        sacc_next      = sacc_reg;
        pot_next       = pot_reg;
        pzero_next     = pzero_reg;
        psat_next      = psat_reg;
        sum_next       = sum_reg;
        zero_flag_next = zero_flag_reg;
        sat_flag_next  = sat_flag_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (load)
        begin
            q_next    = charge;
            dx_next   = {pos_x[eps_pkg::POS_W-1], pos_x}
                      - {center_x[eps_pkg::POS_W-1], center_x};
            dy_next   = {pos_y[eps_pkg::POS_W-1], pos_y}
                      - {center_y[eps_pkg::POS_W-1], center_y};
            dz_next   = {pos_z[eps_pkg::POS_W-1], pos_z}
                      - {center_z[eps_pkg::POS_W-1], center_z};
            last_next = last;
        end

        if (clear)
        begin
            sum_next       = '0;
            zero_flag_next = 1'b0;
            sat_flag_next  = 1'b0;
        end

        case (op)
            eps_pkg::OP_SQ_X:
            begin
                d2_next = D2_W'(prod);
            end
            eps_pkg::OP_SQ_Y, eps_pkg::OP_SQ_Z:
            begin
                d2_next = d2_reg + D2_W'(prod);
            end
            eps_pkg::OP_SQRT_INIT:
            begin
                work_next = d2_reg;
                rem_next  = '0;
                root_next = '0;
            end
            eps_pkg::OP_SQRT_STEP:
            begin
                work_next = {work_reg[D2_W-3:0], 2'b00};
                if (sq_rem >= sq_trial)
                begin
                    rem_next  = REM_W'(sq_rem - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(sq_rem);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            eps_pkg::OP_DIV_INIT:
            begin
                work_next = D2_W'({abs_q, {eps_pkg::FRAC_SH{1'b0}}});
                rem_next  = '0;
            end
            eps_pkg::OP_DIV_STEP:
            begin
                if (dv_rem >= {1'b0, root_reg})
                begin
                    rem_next  = REM_W'(dv_rem - {1'b0, root_reg});
                    work_next = D2_W'({work_reg[QUO_W-2:0], 1'b1});
                end
                else
                begin
                    rem_next  = REM_W'(dv_rem);
                    work_next = D2_W'({work_reg[QUO_W-2:0], 1'b0});
                end
            end
            eps_pkg::OP_ACCUM:
            begin
                if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                begin
                    sum_next      = sum_ext[SUM_W] ? eps_pkg::SUM_MIN : eps_pkg::SUM_MAX;
                    sat_flag_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_ext[SUM_W-1:0];
                end
            end
            eps_pkg::OP_ZERO:
            begin
                zero_flag_next = 1'b1;
            end
            eps_pkg::OP_MUL_HI:
            begin
                sacc_next = SACC_W'(prod);
            end
            eps_pkg::OP_MUL_LO:
            begin
                sacc_next = sacc_reg + SACC_W'(prod >> HALF_W);
            end
            eps_pkg::OP_EMIT:
            begin
                pzero_next = zero_flag_reg;
                psat_next  = sat_flag_reg;
                if (!sum_reg[SUM_W-1])
                begin
                    if (sacc_reg[SACC_W-1:SUM_W-1] != '0)
                    begin
                        pot_next  = eps_pkg::SUM_MAX;
                        psat_next = 1'b1;
                    end
                    else
                    begin
                        pot_next = sacc_reg[SUM_W-1:0];
                    end
                end
                else
                begin
                    if ((sacc_reg[SACC_W-1:SUM_W] != '0)
                        || (sacc_reg[SUM_W-1] && (sacc_reg[SUM_W-2:0] != '0)))
                    begin
                        pot_next  = eps_pkg::SUM_MIN;
                        psat_next = 1'b1;
                    end
                    else
                    begin
                        pot_next = SUM_W'(~sacc_reg[SUM_W-1:0] + 1'b1);
                    end
                end
                out_valid_next = 1'b1;
                sum_next       = '0;
                zero_flag_next = 1'b0;
                sat_flag_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        last_reg  <= last_next;
        d2_reg    <= d2_next;
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        sacc_reg  <= sacc_next;
        pot_reg   <= pot_next;
        pzero_reg <= pzero_next;
        psat_reg  <= psat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            zero_flag_reg <= 1'b0;
            sat_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            zero_flag_reg <= zero_flag_next;
            sat_flag_reg  <= sat_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.d2_zero        = (d2_reg == '0);
    assign stat.last           = last_reg;
    assign stat.emit_ok        = !out_valid_reg || out_ready;
    assign out_valid           = out_valid_reg;
    assign potential           = pot_reg;
    assign zero_distance_seen  = pzero_reg;
    assign saturated           = psat_reg;

endmodule
`default_nettype wire

// ===== sv/electrostatic_potential_sum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// electrostatic_potential_sum
// sums charge / distance to a configured center over a run of point charges
//
// charges: one word per point charge (charge, pos_x/y/z, last). ready is high
//   only while the sequencer is idle; one word is taken at a time.
// results: one word per run, on the word marked last, carrying the scaled
//   sum and the run's zero-distance and saturation flags.
// cfg: write enable, register index and data; write only while idle.
// steps: each charge word runs 3 square steps, 25 root steps,
//   44 divide steps, set-up and sum steps, all through one sequencer.
//   A last word adds the high and low scaling steps and the result step;
//   a word on the center skips the root, divide and sum steps.
// while a result waits on a stalled receiver, the next run proceeds; only
//   the next result step holds until the output register is free.
// a word taken while disabled gives no result and clears the run.
// reset: centers 0, scale 1.0, enabled, sum and flags clear, no result held.
// ----------------------------------------------------------------------------
module electrostatic_potential_sum (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    eps_in_if.sink                                 charges,
    eps_out_if.source                              results,
    input  wire logic                              cfg_wr_en,
    input  wire logic [eps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [eps_pkg::CFG_DAT_W-1:0]     cfg_data
);

    logic [eps_pkg::POS_W-1:0]    center_x_reg, center_x_next;
    logic [eps_pkg::POS_W-1:0]    center_y_reg, center_y_next;
    logic [eps_pkg::POS_W-1:0]    center_z_reg, center_z_next;
    logic [eps_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic                         enable_reg, enable_next;

    logic                         seq_busy;
    logic                         accept;
    logic                         start;
    eps_pkg::eps_op_t             seq_op;
    eps_pkg::eps_stat_t           stat;

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        center_z_next = center_z_reg;
        scale_next    = scale_reg;
        enable_next   = enable_reg;
        if (cfg_wr_en)
        begin
            case (eps_pkg::eps_reg_t'(cfg_index))
                eps_pkg::REG_CENTER_X: center_x_next = cfg_data[eps_pkg::POS_W-1:0];
                eps_pkg::REG_CENTER_Y: center_y_next = cfg_data[eps_pkg::POS_W-1:0];
                eps_pkg::REG_CENTER_Z: center_z_next = cfg_data[eps_pkg::POS_W-1:0];
                eps_pkg::REG_SCALE:    scale_next    = cfg_data[eps_pkg::SCALE_W-1:0];
                eps_pkg::REG_ENABLE:   enable_next   = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= eps_pkg::CENTER_RESET;
            center_y_reg <= eps_pkg::CENTER_RESET;
            center_z_reg <= eps_pkg::CENTER_RESET;
            scale_reg    <= eps_pkg::SCALE_RESET;
            enable_reg   <= 1'b1;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            center_z_reg <= center_z_next;
            scale_reg    <= scale_next;
            enable_reg   <= enable_next;
        end
    end

    assign charges.ready = !seq_busy;
    assign accept        = charges.valid && !seq_busy;
    assign start         = accept && enable_reg;

    eps_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (seq_op),
        .busy  (seq_busy)
    );

    eps_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (start),
        .clear              (accept && !enable_reg),
        .op                 (seq_op),
        .charge             (charges.charge),
        .pos_x              (charges.pos_x),
        .pos_y              (charges.pos_y),
        .pos_z              (charges.pos_z),
        .last               (charges.last),
        .center_x           (center_x_reg),
        .center_y           (center_y_reg),
        .center_z           (center_z_reg),
        .scale_recip        (scale_reg),
        .out_ready          (results.ready),
        .stat               (stat),
        .out_valid          (results.valid),
        .potential          (results.potential),
        .zero_distance_seen (results.zero_distance_seen),
        .saturated          (results.saturated)
    );

    // an enabled word always starts the program
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> seq_busy)
        else $error("program did not start after an enabled word");

    // a result word only appears from the result step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(seq_op == eps_pkg::OP_EMIT))
        else $error("result word raised outside the result step");

    // a word taken while disabled produces nothing
    a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg && !results.valid) |=> !results.valid)
        else $error("result word produced while disabled");

endmodule
`default_nettype wire

// ===== tb/tb_electrostatic_potential_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_electrostatic_potential_sum
// self-checking bench for the point-charge potential sum
//
// sends runs of charge words and predicts each run's scaled sum, zero-distance
// flag and saturation flag from a behavioral model of the fixed-point math:
// exact offsets, integer root, truncating division, clamped sum and scaling.
// directed tests cover reset values, field extremes, sum and scale saturation,
// charges on the center, disable and unknown register writes. random phases
// then vary center, scale and enable, with random gaps and stalls on both
// channels and some phases without any.
// ----------------------------------------------------------------------------
module tb_electrostatic_potential_sum;

    localparam int SUM_W     = eps_pkg::SUM_W;
    localparam int POS_W     = eps_pkg::POS_W;
    localparam int CHG_W     = eps_pkg::CHG_W;
    localparam int SCALE_W   = eps_pkg::SCALE_W;
    localparam int HALF_W    = eps_pkg::HALF_W;
    localparam int FRAC_SH   = eps_pkg::FRAC_SH;
    localparam int CFG_IDX_W = eps_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = eps_pkg::CFG_DAT_W;

    localparam longint RUN_SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint RUN_SUM_LO = -(longint'(1) <<< (SUM_W - 1));
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};
    localparam logic [CHG_W-1:0] CHG_MAX = {1'b0, {(CHG_W - 1){1'b1}}};
    localparam logic [CHG_W-1:0] CHG_MIN = {1'b1, {(CHG_W - 1){1'b0}}};
    localparam logic [CHG_W-1:0] CHG_ONE = CHG_W'(1 << 12);
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 150;

    typedef struct {
        logic [CHG_W-1:0] charge;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic             last;
    } charge_word_t;

    typedef struct {
        logic [SUM_W-1:0] potential;
        logic             zero_seen;
        logic             saturated;
    } potential_word_t;

    typedef enum { PLACE_ANY, PLACE_NEAR, PLACE_ON_CENTER } placement_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    eps_in_if  charge_ch();
    eps_out_if result_ch();

    electrostatic_potential_sum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .charges   (charge_ch),
        .results   (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the registers and of the run in progress
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;
    logic [SCALE_W-1:0]      scale_recip;
    logic                    potential_on;
    longint                  run_sum;
    bit                      run_zero;
    bit                      run_sat;

    potential_word_t pending_potentials[$];
    int errors;
    int words_summed;
    int potentials_checked;
    int zero_runs;
    int saturated_runs;
    bit steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("tb_electrostatic_potential_sum: FAIL");
        $finish;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 27; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic void accumulate_charge(input charge_word_t w);
        longint          q;
        longint          dx;
        longint          dy;
        longint          dz;
        longint          term;
        longint          total;
        logic [63:0]     d2;
        logic [63:0]     mag;
        logic [63:0]     prod;
        bit              neg;
        bit              sat;
        potential_word_t r;
        if (!potential_on)
        begin
            run_sum  = 0;
            run_zero = 1'b0;
            run_sat  = 1'b0;
            return;
        end
        q  = longint'($signed(w.charge));
        dx = longint'($signed(w.pos_x)) - longint'(center_x);
        dy = longint'($signed(w.pos_y)) - longint'(center_y);
        dz = longint'($signed(w.pos_z)) - longint'(center_z);
        d2 = 64'(dx * dx + dy * dy + dz * dz);
        if (d2 == 0)
            run_zero = 1'b1;
        else
        begin
            mag   = 64'(q < 0 ? -q : q) << FRAC_SH;
            mag   = mag / int_sqrt(d2);
            term  = q < 0 ? -longint'(mag) : longint'(mag);
            total = run_sum + term;
            if (total > RUN_SUM_HI)
            begin
                total   = RUN_SUM_HI;
                run_sat = 1'b1;
            end
            else if (total < RUN_SUM_LO)
            begin
                total   = RUN_SUM_LO;
                run_sat = 1'b1;
            end
            run_sum = total;
        end
        if (!w.last)
            return;
        neg  = run_sum < 0;
        mag  = 64'(neg ? -run_sum : run_sum);
        prod = mag * 64'(scale_recip[SCALE_W-1:HALF_W])
             + ((mag * 64'(scale_recip[HALF_W-1:0])) >> HALF_W);
        sat  = run_sat;
        if (!neg && prod > 64'(RUN_SUM_HI))
        begin
            prod = 64'(RUN_SUM_HI);
            sat  = 1'b1;
        end
        if (neg && prod > 64'(-RUN_SUM_LO))
        begin
            prod = 64'(-RUN_SUM_LO);
            sat  = 1'b1;
        end
        r.potential = SUM_W'(neg ? -prod : prod);
        r.zero_seen = run_zero;
        r.saturated = sat;
        pending_potentials.push_back(r);
        zero_runs      += run_zero;
        saturated_runs += sat;
        run_sum  = 0;
        run_zero = 1'b0;
        run_sat  = 1'b0;
    endfunction

    function automatic charge_word_t make_word(input logic [CHG_W-1:0] q,
                                               input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y,
                                               input logic [POS_W-1:0] z,
                                               input logic last);
        charge_word_t w;
        w.charge = q;
        w.pos_x  = x;
        w.pos_y  = y;
        w.pos_z  = z;
        w.last   = last;
        return w;
    endfunction

    function automatic logic [POS_W-1:0] near(input logic [POS_W-1:0] c);
        int o;
        o = int'($urandom_range(0, 16)) - 8;
        return c + POS_W'(o);
    endfunction

    function automatic charge_word_t random_word(input logic last);
        placement_t p;
        int         r;
        r = $urandom_range(0, 99);
        p = r < 55 ? PLACE_ANY : (r < 90 ? PLACE_NEAR : PLACE_ON_CENTER);
        case (p)
            PLACE_ANY:
                return make_word(CHG_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                                 POS_W'($urandom), last);
            PLACE_NEAR:
                return make_word(CHG_W'($urandom), near(center_x), near(center_y),
                                 near(center_z), last);
            default:
                return make_word(CHG_W'($urandom), center_x, center_y, center_z, last);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return '0;
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return SCALE_MAX;
            2:       return eps_pkg::SCALE_RESET;
            3:       return SCALE_W'($urandom_range(0, 1 << 17));
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    // holds valid high across back-to-back words
    task automatic send_charge(input charge_word_t w);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            charge_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        charge_ch.valid  <= 1'b1;
        charge_ch.charge <= w.charge;
        charge_ch.pos_x  <= w.pos_x;
        charge_ch.pos_y  <= w.pos_y;
        charge_ch.pos_z  <= w.pos_z;
        charge_ch.last   <= w.last;
        do
            @(posedge clk);
        while (!charge_ch.ready);
        if (potential_on)
            words_summed++;
        accumulate_charge(w);
    endtask

    task automatic settle();
        charge_ch.valid <= 1'b0;
        while (pending_potentials.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            eps_pkg::REG_CENTER_X: center_x = data[POS_W-1:0];
            eps_pkg::REG_CENTER_Y: center_y = data[POS_W-1:0];
            eps_pkg::REG_CENTER_Z: center_z = data[POS_W-1:0];
            eps_pkg::REG_SCALE:    scale_recip = data[SCALE_W-1:0];
            eps_pkg::REG_ENABLE:   potential_on = data[0];
            default:               ;
        endcase
    endtask

    task automatic configure(input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                             input logic [POS_W-1:0] cz, input logic [SCALE_W-1:0] scale,
                             input logic on);
        write_reg(eps_pkg::REG_CENTER_X, {8'($urandom), cx});
        write_reg(eps_pkg::REG_CENTER_Y, {8'($urandom), cy});
        write_reg(eps_pkg::REG_CENTER_Z, {8'($urandom), cz});
        write_reg(eps_pkg::REG_SCALE, scale);
        write_reg(eps_pkg::REG_ENABLE, {31'($urandom), on});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_charge(make_word(CHG_MAX, POS_W'(1), '0, '0, 1'b1));
        send_charge(make_word(CHG_MIN, '0, '0, '0, 1'b1));
        send_charge(make_word(CHG_MIN, POS_MAX, POS_MIN, POS_MAX, 1'b1));
        send_charge(make_word('0, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), 1'b1));
        send_charge(make_word(CHG_ONE, '0, '0, '0, 1'b0));
        send_charge(make_word(CHG_ONE, '0, POS_W'(1 << 16), '0, 1'b1));
        settle();
    endtask

    task automatic test_sum_saturation();
        for (int i = 0; i < 17; i++)
            send_charge(make_word(CHG_MAX, '0, '0, '1, i == 16));
        settle();
    endtask

    task automatic test_scale_extremes();
        configure('0, '0, '0, SCALE_MAX, 1'b1);
        send_charge(make_word(CHG_MIN, '0, POS_W'(1), '0, 1'b1));
        settle();
        configure('0, '0, '0, '0, 1'b1);
        send_charge(make_word(CHG_MAX, POS_W'(1), POS_W'(1), POS_W'(1), 1'b1));
        settle();
    endtask

    task automatic test_center_extremes();
        configure(POS_MAX, POS_MIN, POS_MAX, eps_pkg::SCALE_RESET, 1'b1);
        send_charge(make_word(CHG_MAX, POS_MIN, POS_MAX, POS_MIN, 1'b1));
        send_charge(make_word(CHG_MIN, POS_MAX, POS_MIN, POS_MAX, 1'b1));
        settle();
        configure(POS_MIN, POS_MIN, POS_MIN, eps_pkg::SCALE_RESET, 1'b1);
        send_charge(make_word(CHG_MIN, POS_MAX, POS_MAX, POS_MAX, 1'b1));
        settle();
    endtask

    task automatic test_disable();
        configure('0, '0, '0, eps_pkg::SCALE_RESET, 1'b1);
        send_charge(random_word(1'b0));
        send_charge(random_word(1'b0));
        settle();
        write_reg(eps_pkg::REG_ENABLE, '0);
        cfg_wr_en <= 1'b0;
        send_charge(random_word(1'b0));
        send_charge(random_word(1'b1));
        settle();
        write_reg(eps_pkg::REG_ENABLE, CFG_DAT_W'(1));
        write_reg(CFG_IDX_W'(eps_pkg::REG_ENABLE) + CFG_IDX_W'($urandom_range(1, 3)),
                  $urandom);
        cfg_wr_en <= 1'b0;
        send_charge(make_word(CHG_ONE, POS_W'(1 << 16), '0, '0, 1'b1));
        settle();
    endtask

    task automatic test_random_phases();
        int           words;
        int           len;
        int           axis;
        bit           neg_run;
        logic [POS_W-1:0] step;
        charge_word_t w;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            steady = (ph == 2) || (ph == 6);
            if (ph == 0)
                configure(POS_MAX, POS_MAX, POS_MAX, SCALE_MAX, 1'b1);
            else if (ph == 1)
                configure(POS_MIN, POS_MIN, POS_MIN, '0, 1'b1);
            else
                configure(pick_center(), pick_center(), pick_center(), pick_scale(), ph != 4);
            words = 0;
            while (words < (potential_on ? PHASE_WORDS : 30))
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // charges of one sign next to the center drive the sum into the clamp
                    len     = $urandom_range(17, 20);
                    neg_run = 1'($urandom_range(0, 1));
                    for (int i = 0; i < len; i++)
                    begin
                        w = make_word(neg_run ? CHG_MIN : CHG_MAX, center_x, center_y,
                                      center_z, i == len - 1);
                        axis = $urandom_range(0, 2);
                        step = $urandom_range(0, 1) ? POS_W'(1) : '1;
                        case (axis)
                            0:       w.pos_x = w.pos_x + step;
                            1:       w.pos_y = w.pos_y + step;
                            default: w.pos_z = w.pos_z + step;
                        endcase
                        send_charge(w);
                    end
                end
                else
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_charge(random_word(i == len - 1));
                end
                words += len;
            end
            settle();
        end
        steady = 1'b0;
    endtask

    initial
    begin : result_sink
        int              stall;
        potential_word_t want;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_potentials.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: potential %h zero %b saturated %b",
                             $time, result_ch.potential, result_ch.zero_distance_seen,
                             result_ch.saturated);
                end
                else
                begin
                    want = pending_potentials.pop_front();
                    potentials_checked++;
                    if (result_ch.potential !== want.potential)
                    begin
                        errors++;
                        $display("%0t potential: expected %h actual %h",
                                 $time, want.potential, result_ch.potential);
                    end
                    if (result_ch.zero_distance_seen !== want.zero_seen)
                    begin
                        errors++;
                        $display("%0t zero_distance_seen: expected %b actual %b",
                                 $time, want.zero_seen, result_ch.zero_distance_seen);
                    end
                    if (result_ch.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t saturated: expected %b actual %b",
                                 $time, want.saturated, result_ch.saturated);
                    end
                end
                stall = draw_wait();
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        charge_ch.valid  = 1'b0;
        charge_ch.charge = '0;
        charge_ch.pos_x  = '0;
        charge_ch.pos_y  = '0;
        charge_ch.pos_z  = '0;
        charge_ch.last   = 1'b0;
        center_x         = eps_pkg::CENTER_RESET;
        center_y         = eps_pkg::CENTER_RESET;
        center_z         = eps_pkg::CENTER_RESET;
        scale_recip      = eps_pkg::SCALE_RESET;
        potential_on     = 1'b1;
        run_sum          = 0;
        run_zero         = 1'b0;
        run_sat          = 1'b0;
        errors           = 0;
        words_summed     = 0;
        potentials_checked = 0;
        zero_runs        = 0;
        saturated_runs   = 0;
        steady           = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_sum_saturation();
        test_scale_extremes();
        test_center_extremes();
        test_disable();
        test_random_phases();
        settle();

        $display("summed %0d charge words into %0d checked potentials", words_summed,
                 potentials_checked);
        $display("%0d runs saw a charge on the center, %0d runs saturated", zero_runs,
                 saturated_runs);
        if (errors == 0)
            $display("tb_electrostatic_potential_sum: PASS");
        else
            $display("tb_electrostatic_potential_sum: FAIL");
        $finish;
    end

endmodule

// ===== electrostatic_potential_sum.f =====
sv/eps_pkg.sv
sv/eps_in_if.sv
sv/eps_out_if.sv
sv/eps_seq.sv
sv/eps_dp.sv
sv/electrostatic_potential_sum.sv
tb/tb_electrostatic_potential_sum.sv
